// File: hdl/esd_pkg.sv
// Package with the shared constants and types of the escape sequence decoder.
package esd_pkg;

	localparam int CHAR_BITS_DEFAULT = 16;
	localparam int UNIT_W = 16;
	localparam int NUM_W = 31;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);

	localparam logic [NUM_W-1:0] NUM_MAX = '1;

	// Decoder modes.
	localparam logic [1:0] MODE_PLAIN = 2'd0;
	localparam logic [1:0] MODE_ESCAPE = 2'd1;
	localparam logic [1:0] MODE_HEX = 2'd2;
	localparam logic [1:0] MODE_OCTAL = 2'd3;

	// Characters the decoder looks for.
	localparam logic [UNIT_W-1:0] CH_BACKSLASH = 16'h005C;
	localparam logic [UNIT_W-1:0] CH_END = 16'h0000;
	localparam logic [UNIT_W-1:0] CH_LOW_A = 16'h0061;
	localparam logic [UNIT_W-1:0] CH_LOW_B = 16'h0062;
	localparam logic [UNIT_W-1:0] CH_LOW_F = 16'h0066;
	localparam logic [UNIT_W-1:0] CH_LOW_N = 16'h006E;
	localparam logic [UNIT_W-1:0] CH_LOW_R = 16'h0072;
	localparam logic [UNIT_W-1:0] CH_LOW_T = 16'h0074;
	localparam logic [UNIT_W-1:0] CH_LOW_V = 16'h0076;
	localparam logic [UNIT_W-1:0] CH_LOW_X = 16'h0078;
	localparam logic [UNIT_W-1:0] CH_UP_A = 16'h0041;
	localparam logic [UNIT_W-1:0] CH_UP_F = 16'h0046;
	localparam logic [UNIT_W-1:0] CH_DIG_0 = 16'h0030;
	localparam logic [UNIT_W-1:0] CH_DIG_7 = 16'h0037;
	localparam logic [UNIT_W-1:0] CH_DIG_9 = 16'h0039;

	// Control codes produced by the single letter escapes.
	localparam logic [UNIT_W-1:0] CC_BEL = 16'h0007;
	localparam logic [UNIT_W-1:0] CC_BS = 16'h0008;
	localparam logic [UNIT_W-1:0] CC_HT = 16'h0009;
	localparam logic [UNIT_W-1:0] CC_LF = 16'h000A;
	localparam logic [UNIT_W-1:0] CC_VT = 16'h000B;
	localparam logic [UNIT_W-1:0] CC_FF = 16'h000C;
	localparam logic [UNIT_W-1:0] CC_CR = 16'h000D;

	typedef struct packed {
		logic [UNIT_W-1:0] out_unit;
		logic              ends_string;
	} result_t;

endpackage

// File: hdl/esd_in_if.sv
// Input channel of the escape sequence decoder: one code unit per word.
interface esd_in_if;
	logic                        valid;
	logic                        ready;
	logic [esd_pkg::UNIT_W-1:0]  code_unit;

	modport source (output valid, output code_unit, input ready);
	modport sink (input valid, input code_unit, output ready);
endinterface

// File: hdl/esd_out_if.sv
// Output channel of the escape sequence decoder: one decoded unit per word.
interface esd_out_if;
	logic                        valid;
	logic                        ready;
	logic [esd_pkg::UNIT_W-1:0]  out_unit;
	logic                        ends_string;

	modport source (output valid, output out_unit, output ends_string, input ready);
	modport sink (input valid, input out_unit, input ends_string, output ready);
endinterface

// File: hdl/escape_sequence_decoder.sv
// Escape sequence decoder: input register, decode logic and a four word result queue.
// The input register holds an accepted word while it is decoded; its results are written into
// the result queue and show on the output from there.
// Throughput: one input word per cycle while the result queue holds two words or
// fewer; a word that yields two results writes both at once and the output drains them in turn.
// Reset clears the mode, the number accumulator and the queue; the string starts in plain text.
module escape_sequence_decoder #(
	parameter int CHAR_BITS = esd_pkg::CHAR_BITS_DEFAULT
) (
	input logic      clk,
	input logic      arst_n,
	esd_in_if.sink   din,
	esd_out_if.source dout
);

	localparam logic [esd_pkg::UNIT_W-1:0] CHAR_MASK = (CHAR_BITS >= esd_pkg::UNIT_W) ?
		'1 : esd_pkg::UNIT_W'((32'd1 << CHAR_BITS) - 32'd1);

	// Input register.
	logic                          valid_s1;
	logic [esd_pkg::UNIT_W-1:0]    code_s1;

	// Decoder state.
	logic [1:0]                    mode_q;
	logic [esd_pkg::NUM_W-1:0]     value_q;
	logic                          ovf_q;

	// Result queue.
	esd_pkg::result_t              fifo_q [esd_pkg::FIFO_DEPTH];
	logic [esd_pkg::FIFO_AW-1:0]   wp_q;
	logic [esd_pkg::FIFO_AW-1:0]   rp_q;
	logic [esd_pkg::FIFO_AW:0]     count_q;

	logic                          advance;
	logic                          pop;

	logic [1:0]                    n_mode;
	logic [esd_pkg::NUM_W-1:0]     n_value;
	logic                          n_ovf;
	esd_pkg::result_t              res_a;
	esd_pkg::result_t              res_b;
	logic [1:0]                    n_res;

	logic [3:0]                    dig;
	logic                          is_hex;
	logic                          is_oct;
	logic                          emit_num;
	logic                          do_plain;
	esd_pkg::result_t              plain_res;
	logic                          plain_has;

	// The queue must have room for two results before a word is decoded.
	assign advance = valid_s1 && (count_q <= (esd_pkg::FIFO_AW+1)'(esd_pkg::FIFO_DEPTH - 2));
	assign din.ready = !valid_s1 || advance;
	assign pop = dout.valid && dout.ready;
	assign dout.valid = (count_q != '0);
	assign dout.out_unit = fifo_q[rp_q].out_unit;
	assign dout.ends_string = fifo_q[rp_q].ends_string;

	always_comb begin
		dig = code_s1[3:0];
		is_hex = 1'b0;
		is_oct = 1'b0;
		if (code_s1 >= esd_pkg::CH_DIG_0 && code_s1 <= esd_pkg::CH_DIG_9) begin
			is_hex = 1'b1;
			is_oct = (code_s1 <= esd_pkg::CH_DIG_7);
		end else if ((code_s1 >= esd_pkg::CH_LOW_A && code_s1 <= esd_pkg::CH_LOW_F) ||
				(code_s1 >= esd_pkg::CH_UP_A && code_s1 <= esd_pkg::CH_UP_F)) begin
			is_hex = 1'b1;
			dig = code_s1[3:0] + 4'd9;
		end
	end

	always_comb begin
		n_mode = mode_q;
		n_value = value_q;
		n_ovf = ovf_q;
		res_a = '0;
		res_b = '0;
		n_res = 2'd0;
		emit_num = 1'b0;
		do_plain = 1'b0;
		plain_res = '0;
		plain_has = 1'b0;

		case (mode_q)
			esd_pkg::MODE_HEX, esd_pkg::MODE_OCTAL: begin
				if ((mode_q == esd_pkg::MODE_HEX) ? is_hex : is_oct) begin
					if (!ovf_q) begin
						if (mode_q == esd_pkg::MODE_HEX) begin
							if (value_q[esd_pkg::NUM_W-1 -: 4] != '0) begin
								n_ovf = 1'b1;
								n_value = esd_pkg::NUM_MAX;
							end else begin
								n_value = {value_q[esd_pkg::NUM_W-5:0], dig};
							end
						end else begin
							if (value_q[esd_pkg::NUM_W-1 -: 3] != '0) begin
								n_ovf = 1'b1;
								n_value = esd_pkg::NUM_MAX;
							end else begin
								n_value = {value_q[esd_pkg::NUM_W-4:0], dig[2:0]};
							end
						end
					end
				end else begin
					// The digit run ends: emit its number, then treat this word as plain text.
					emit_num = 1'b1;
					n_mode = esd_pkg::MODE_PLAIN;
					n_value = '0;
					n_ovf = 1'b0;
					do_plain = 1'b1;
				end
			end
			esd_pkg::MODE_ESCAPE: begin
				n_mode = esd_pkg::MODE_PLAIN;
				plain_has = 1'b1;
				plain_res.out_unit = code_s1;
				case (code_s1)
					esd_pkg::CH_LOW_A: plain_res.out_unit = esd_pkg::CC_BEL;
					esd_pkg::CH_LOW_B: plain_res.out_unit = esd_pkg::CC_BS;
					esd_pkg::CH_LOW_F: plain_res.out_unit = esd_pkg::CC_FF;
					esd_pkg::CH_LOW_N: plain_res.out_unit = esd_pkg::CC_LF;
					esd_pkg::CH_LOW_R: plain_res.out_unit = esd_pkg::CC_CR;
					esd_pkg::CH_LOW_T: plain_res.out_unit = esd_pkg::CC_HT;
					esd_pkg::CH_LOW_V: plain_res.out_unit = esd_pkg::CC_VT;
					esd_pkg::CH_LOW_X: begin
						plain_has = 1'b0;
						n_mode = esd_pkg::MODE_HEX;
						n_value = '0;
						n_ovf = 1'b0;
					end
					esd_pkg::CH_END: plain_res.ends_string = 1'b1;
					default: begin
						if (is_oct) begin
							plain_has = 1'b0;
							n_mode = esd_pkg::MODE_OCTAL;
							n_value = esd_pkg::NUM_W'(code_s1[2:0]);
							n_ovf = 1'b0;
						end
					end
				endcase
			end
			default: begin
				do_plain = 1'b1;
			end
		endcase

		if (do_plain) begin
			if (code_s1 == esd_pkg::CH_END) begin
				plain_has = 1'b1;
				plain_res.ends_string = 1'b1;
			end else if (code_s1 == esd_pkg::CH_BACKSLASH) begin
				n_mode = esd_pkg::MODE_ESCAPE;
			end else begin
				plain_has = 1'b1;
				plain_res.out_unit = code_s1;
			end
		end

		plain_res.out_unit = plain_res.out_unit & CHAR_MASK;

		if (emit_num) begin
			res_a.out_unit = value_q[esd_pkg::UNIT_W-1:0] & CHAR_MASK;
			res_a.ends_string = 1'b0;
			res_b = plain_res;
			n_res = plain_has ? 2'd2 : 2'd1;
		end else begin
			res_a = plain_res;
			n_res = plain_has ? 2'd1 : 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q <= esd_pkg::MODE_PLAIN;
			value_q <= '0;
			ovf_q <= 1'b0;
			wp_q <= '0;
			rp_q <= '0;
			count_q <= '0;
		end else begin
			if (din.ready) begin
				valid_s1 <= din.valid;
			end
			if (advance) begin
				mode_q <= n_mode;
				value_q <= n_value;
				ovf_q <= n_ovf;
				wp_q <= wp_q + esd_pkg::FIFO_AW'(n_res);
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			count_q <= count_q + (advance ? (esd_pkg::FIFO_AW+1)'(n_res) : '0)
				- (esd_pkg::FIFO_AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (din.valid && din.ready) begin
			code_s1 <= din.code_unit;
		end
		if (advance && n_res != 2'd0) begin
			fifo_q[wp_q] <= res_a;
		end
		if (advance && n_res == 2'd2) begin
			fifo_q[wp_q + 1'b1] <= res_b;
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (esd_pkg::FIFO_AW+1)'(esd_pkg::FIFO_DEPTH))
		else $error("result queue holds more words than it has entries");

	a_number_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == esd_pkg::MODE_PLAIN || mode_q == esd_pkg::MODE_ESCAPE) |->
		(value_q == '0 && !ovf_q))
		else $error("number accumulator not cleared outside a digit run");

	a_ovf_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> value_q == esd_pkg::NUM_MAX)
		else $error("overflowed number is not saturated");

	a_escape_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && mode_q == esd_pkg::MODE_ESCAPE) |=> mode_q != esd_pkg::MODE_ESCAPE)
		else $error("escape mode lasted past the escaped word");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		($past(count_q) == '0 && !$past(advance)) |-> count_q == '0)
		else $error("result queue count changed without a push");
`endif

endmodule
